FILE: sv/llf_pkg.sv
`default_nettype none
package llf_pkg;

   localparam int STAMP_LEN = 12;
   localparam int WIN_LEN   = STAMP_LEN + 1;
   localparam int FILL_W    = $clog2(WIN_LEN + 1);
   localparam int IDX_W     = $clog2(WIN_LEN);

   localparam int STAMP_COLON_POS = 2;
   localparam int STAMP_DOT_POS   = 5;

   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   localparam logic [7:0] SUBST_LF_RESET = 8'd30;
   localparam logic [7:0] SUBST_CR_RESET = 8'd29;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBST_LF = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBST_CR = 2'd2;

   localparam logic MODE_FLATTEN   = 1'b0;
   localparam logic MODE_UNFLATTEN = 1'b1;

   typedef enum logic {
      ST_RUN,
      ST_FLUSH
   } state_type;

   function automatic logic is_dec_char(input logic [7:0] b);
      return b inside {[CHAR_ZERO:CHAR_NINE]};
   endfunction

endpackage
`default_nettype wire

FILE: sv/log_line_flattener_unit.sv
// channel  | ports                                   | beat
// ---------+-----------------------------------------+------------------------------
// req      | req_valid req_stall req_data_byte/_last | one raw byte of the log file
// rsp      | rsp_valid rsp_stall rsp_out_byte/_last  | one transformed byte
// csr      | csr_wr_en csr_index csr_wdata           | one register write
//
// one byte per cycle while req_stall is low; output trails input by 13 bytes through a shift window
// a beat with req_last_byte set starts a flush: the remaining bytes (up to 13)
// leave one per cycle while the output queue has room, and req is stalled until the final one is queued
// a two-entry output queue parts rsp_stall from req_stall
// reset is synchronous; it empties the window and the queue and restores registers
`default_nettype none
module log_line_flattener_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [7:0]                     req_data_byte,
   input  wire logic                           req_last_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_out_last,
   input  wire logic                           csr_wr_en,
   input  wire logic [llf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [7:0]                     csr_wdata
);

   // configuration
   logic       mode_ff;
   logic [7:0] subst_lf_ff;
   logic [7:0] subst_cr_ff;

   // window: index 0 is the newest stored byte
   logic [7:0] win_ff [llf_pkg::WIN_LEN];
   logic [7:0] win_in [llf_pkg::WIN_LEN];
   logic [7:0] mod_win [llf_pkg::WIN_LEN];
   logic [7:0] mod_new;
   logic [7:0] stamp_bytes [llf_pkg::STAMP_LEN];
   logic       stamp_ok;
   logic       held_full;

   logic [llf_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [llf_pkg::IDX_W-1:0]  rd_idx;

   llf_pkg::state_type state_ff, state_in;

   logic       accept;
   logic       push;
   logic [7:0] push_byte;
   logic       push_last;
   logic       pop;

   // output queue
   logic [7:0] q_byte_ff [2];
   logic       q_last_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign held_full = (fill_ff == llf_pkg::FILL_W'(llf_pkg::WIN_LEN));
   assign rd_idx    = llf_pkg::IDX_W'(fill_ff - llf_pkg::FILL_W'(1));

   // timestamp test over the 12 newest bytes, oldest first
   always_comb begin
      stamp_bytes[llf_pkg::STAMP_LEN-1] = req_data_byte;
      for (int i = 0; i < llf_pkg::STAMP_LEN - 1; i++) begin
         stamp_bytes[i] = win_ff[llf_pkg::STAMP_LEN-2-i];
      end
      stamp_ok = 1'b1;
      for (int i = 0; i < llf_pkg::STAMP_LEN; i++) begin
         if (i == llf_pkg::STAMP_COLON_POS) begin
            if (stamp_bytes[i] != llf_pkg::CHAR_COLON) stamp_ok = 1'b0;
         end else if (i == llf_pkg::STAMP_DOT_POS) begin
            if (stamp_bytes[i] != llf_pkg::CHAR_DOT) stamp_ok = 1'b0;
         end else if (!llf_pkg::is_dec_char(stamp_bytes[i])) begin
            stamp_ok = 1'b0;
         end
      end
   end

   // rewrite of the window for the incoming byte
   always_comb begin
      mod_win = win_ff;
      mod_new = req_data_byte;
      if (mode_ff == llf_pkg::MODE_FLATTEN) begin
         // the line feed under test sits 12 bytes behind the incoming one
         if (fill_ff >= llf_pkg::FILL_W'(llf_pkg::STAMP_LEN)
             && win_ff[llf_pkg::WIN_LEN-2] == llf_pkg::BYTE_LF && !stamp_ok) begin
            mod_win[llf_pkg::WIN_LEN-2] = subst_lf_ff;
            if (held_full && win_ff[llf_pkg::WIN_LEN-1] == llf_pkg::BYTE_CR) begin
               mod_win[llf_pkg::WIN_LEN-1] = subst_cr_ff;
            end
         end
      end else begin
         if (req_data_byte == subst_lf_ff) begin
            mod_new = llf_pkg::BYTE_LF;
            if (fill_ff != '0 && win_ff[0] == subst_cr_ff) begin
               mod_win[0] = llf_pkg::BYTE_CR;
            end
         end
      end
      win_in[0] = mod_new;
      for (int k = 1; k < llf_pkg::WIN_LEN; k++) begin
         win_in[k] = mod_win[k-1];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         llf_pkg::ST_RUN: begin
            if (accept && req_last_byte) state_in = llf_pkg::ST_FLUSH;
         end
         llf_pkg::ST_FLUSH: begin
            if (push && push_last) state_in = llf_pkg::ST_RUN;
         end
         default: state_in = llf_pkg::ST_RUN;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      push      = 1'b0;
      push_byte = mod_win[llf_pkg::WIN_LEN-1];
      push_last = 1'b0;
      case (state_ff)
         llf_pkg::ST_RUN: begin
            req_stall = (cnt_ff == 2'd2);
            push      = accept && held_full;
         end
         llf_pkg::ST_FLUSH: begin
            push      = (cnt_ff != 2'd2);
            push_byte = win_ff[rd_idx];
            push_last = (fill_ff == llf_pkg::FILL_W'(1));
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      if (state_ff == llf_pkg::ST_RUN) begin
         if (accept && !held_full) fill_in = fill_ff + llf_pkg::FILL_W'(1);
      end else if (push) begin
         fill_in = fill_ff - llf_pkg::FILL_W'(1);
      end
   end

   always_comb begin
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= llf_pkg::MODE_FLATTEN;
         subst_lf_ff <= llf_pkg::SUBST_LF_RESET;
         subst_cr_ff <= llf_pkg::SUBST_CR_RESET;
         state_ff    <= llf_pkg::ST_RUN;
         fill_ff     <= '0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               llf_pkg::CSR_MODE:     mode_ff     <= csr_wdata[0];
               llf_pkg::CSR_SUBST_LF: subst_lf_ff <= csr_wdata;
               llf_pkg::CSR_SUBST_CR: subst_cr_ff <= csr_wdata;
               default: ;
            endcase
         end
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) win_ff <= win_in;
      if (push) begin
         q_byte_ff[wr_ptr_ff] <= push_byte;
         q_last_ff[wr_ptr_ff] <= push_last;
      end
   end

   assign rsp_valid    = (cnt_ff != 2'd0);
   assign rsp_out_byte = q_byte_ff[rd_ptr_ff];
   assign rsp_out_last = q_last_ff[rd_ptr_ff];

endmodule
`default_nettype wire

FILE: sv/llf_checker.sv
`default_nettype none
module llf_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic [7:0]                     req_data_byte,
   input wire logic                           req_last_byte,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [7:0]                     rsp_out_byte,
   input wire logic                           rsp_out_last,
   input wire logic                           csr_wr_en,
   input wire logic [llf_pkg::CSR_IDX_W-1:0]  csr_index,
   input wire logic [7:0]                     csr_wdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last))
      else $error("rsp beat changed while stalled");

   // a final byte starts a flush, which closes the input
   a_flush_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_byte |=> req_stall)
      else $error("input open right after final byte");

   // reset leaves an empty queue and an open input
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("bad state after reset");

endmodule

bind log_line_flattener_unit llf_checker u_llf_checker (.*);
`default_nettype wire
